// ----- rtl/core/salc_pkg.sv -----
// Shared types, constants and helpers of the set-associative LRU tag store.
// No dependencies; imported by salc_way_sel and set_assoc_lru_cache_tags.
package salc_pkg;

  // default sizes of the tag store
  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  // field and register widths
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int OFF_W      = 5;
  localparam int SETB_W     = 4;
  localparam int WAYS_W     = 4;
  localparam int WAY_OUT_W  = 3;
  localparam int WAY_IDX_W  = 5;   // enough for up to 32 ways
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int OUT_DATA_W = 72;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // configuration reset values
  localparam logic [OFF_W-1:0]  OFFSET_BITS_RST = 5'd5;
  localparam logic [SETB_W-1:0] SET_BITS_RST    = 4'd6;
  localparam logic [WAYS_W-1:0] WAYS_IN_USE_RST = 4'd4;

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // one way of a set as held in the row memory
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [CNT_W-1:0]  stamp;
  } line_t;

  // outcome of the way search
  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [WAY_IDX_W-1:0] pick;
  } sel_res_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  // saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_SAT) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/core/salc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/salc_way_sel.sv -----
// Way search of one set: tag match, first free way and LRU victim.
// Depends on salc_pkg (line_t, sel_res_t, widths).
module salc_way_sel #(
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  salc_pkg::line_t [MAX_WAYS-1:0]       row,
  input  logic                                 row_ok,
  input  logic [salc_pkg::ADDR_W-1:0]          tag,
  input  logic [$clog2(MAX_WAYS+1)-1:0]        ways,
  output salc_pkg::sel_res_t                   res
);
  import salc_pkg::*;

  localparam int IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int LEAVES = 1 << IDX_W;

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] line_ok;

  logic             leaf_ok [LEAVES];
  logic [CNT_W-1:0] leaf_st [LEAVES];
  logic [IDX_W-1:0] leaf_ix [LEAVES];

  logic             node_ok [2*LEAVES];
  logic [CNT_W-1:0] node_st [2*LEAVES];
  logic [IDX_W-1:0] node_ix [2*LEAVES];

  logic             hit;
  logic [IDX_W-1:0] hit_ix;
  logic             free;
  logic [IDX_W-1:0] free_ix;

  // per-way flags and tree leaves
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < MAX_WAYS) begin : g_way
      assign in_use[g]  = ways > WCNT_W'(g);
      assign line_ok[g] = row_ok & row[g].valid;
      assign leaf_ok[g] = in_use[g];
      assign leaf_st[g] = row[g].stamp;
      assign leaf_ix[g] = IDX_W'(g);
    end else begin : g_pad
      assign leaf_ok[g] = 1'b0;
      assign leaf_st[g] = '0;
      assign leaf_ix[g] = IDX_W'(g);
    end
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit     = 1'b0;
    hit_ix  = '0;
    free    = 1'b0;
    free_ix = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && line_ok[w] && (row[w].tag == tag)) begin
        hit    = 1'b1;
        hit_ix = IDX_W'(w);
      end
      if (in_use[w] && !line_ok[w]) begin
        free    = 1'b1;
        free_ix = IDX_W'(w);
      end
    end
  end

  // smallest stamp by a comparator tree, the left (lower) way wins ties
  always_comb begin
    node_ok[0] = 1'b0;
    node_st[0] = '0;
    node_ix[0] = '0;
    for (int i = 0; i < LEAVES; i++) begin
      node_ok[LEAVES+i] = leaf_ok[i];
      node_st[LEAVES+i] = leaf_st[i];
      node_ix[LEAVES+i] = leaf_ix[i];
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      if (node_ok[2*i+1] && (!node_ok[2*i] || (node_st[2*i+1] < node_st[2*i]))) begin
        node_ok[i] = 1'b1;
        node_st[i] = node_st[2*i+1];
        node_ix[i] = node_ix[2*i+1];
      end else begin
        node_ok[i] = node_ok[2*i];
        node_st[i] = node_st[2*i];
        node_ix[i] = node_ix[2*i];
      end
    end
  end

  // hit first, then a free way, else the victim
  always_comb begin
    res.hit     = hit;
    res.evicted = !hit && !free;
    priority if (hit) begin
      res.pick = WAY_IDX_W'(hit_ix);
    end else if (free) begin
      res.pick = WAY_IDX_W'(free_ix);
    end else begin
      res.pick = WAY_IDX_W'(node_ix[1]);
    end
  end

endmodule

// ----- rtl/core/set_assoc_lru_cache_tags.sv -----
// Tag store of a set-associative cache with true LRU replacement.
// Flow: the row of an accepted item is read from the row memory, then the lookup state updates
// the row and registers the result.
// Items are taken one at a time: a new item is accepted only in the idle state, after the
// read-then-write-back of the last one; the lookup waits while a finished result is not taken.
// Reset: per-set row flags, counters and configuration are cleared at once; no clearing pass.
// Depends on salc_pkg, salc_ram and salc_way_sel.
module set_assoc_lru_cache_tags #(
  parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [salc_pkg::ADDR_W-1:0]         in_tdata,   // address[31:0]
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit[0], way_used[3:1], evicted[4], hit_total[36:5], miss_total[68:37], zero[71:69]
  output logic [salc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import salc_pkg::*;

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int IDX_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int ROW_W   = MAX_WAYS * $bits(line_t);

  state_t state_r, state_nxt;

  logic [OFF_W-1:0]  offset_bits_r;
  logic [SETB_W-1:0] set_bits_r;
  logic [WAYS_W-1:0] ways_in_use_r;

  logic [MAX_SETS-1:0] row_seen_r;
  logic                row_ok_r;
  logic [SET_W-1:0]    set_r;
  logic [ADDR_W-1:0]   tag_r;

  logic [CNT_W-1:0] access_count_r, hit_count_r, miss_count_r;
  logic [CNT_W-1:0] access_nxt, hit_nxt, miss_nxt;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic              in_accept;
  logic              lookup_done;
  logic [SETB_W-1:0] sb_eff;
  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] set_mask;
  logic [ADDR_W-1:0] set_full;
  logic [SET_W-1:0]  set_idx;
  logic [5:0]        tag_sh;
  logic [ADDR_W-1:0] tag_in;
  logic [WCNT_W-1:0] ways_eff;

  line_t [MAX_WAYS-1:0] row_rd;
  line_t [MAX_WAYS-1:0] row_wr;
  logic  [ROW_W-1:0]    row_rd_bits;
  sel_res_t             sel;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_BITS_RST;
      set_bits_r    <= SET_BITS_RST;
      ways_in_use_r <= WAYS_IN_USE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: offset_bits_r <= cfg_data[OFF_W-1:0];
        CFG_SET_BITS:    set_bits_r    <= cfg_data[SETB_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use_r <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // address split, set bits clamped to what the store holds
  always_comb begin
    sb_eff   = (set_bits_r > SETB_W'(SET_LIM)) ? SETB_W'(SET_LIM) : set_bits_r;
    shifted  = in_tdata >> offset_bits_r;
    set_mask = (ADDR_W'(1) << sb_eff) - ADDR_W'(1);
    set_full = shifted & set_mask;
    set_idx  = set_full[SET_W-1:0];
    tag_sh   = 6'(offset_bits_r) + 6'(sb_eff);
    tag_in   = tag_sh[5] ? '0 : (in_tdata >> tag_sh[4:0]);
  end

  // associativity clamped to 1..MAX_WAYS
  always_comb begin
    priority if (ways_in_use_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (6'(ways_in_use_r) > 6'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use_r);
    end
  end

  // control state machine: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_LOOKUP;
      S_LOOKUP: if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state machine: outputs
  always_comb begin
    in_tready   = 1'b0;
    lookup_done = 1'b0;
    unique case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_LOOKUP: lookup_done = !out_tvalid_r || out_tready;
      default:  ;
    endcase
  end

  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the split address of the accepted item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      set_r    <= set_idx;
      tag_r    <= tag_in;
      row_ok_r <= row_seen_r[set_idx];
    end
  end

  // row memory: one row of MAX_WAYS lines per set
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (lookup_done),
    .wr_addr (set_r),
    .wr_data (row_wr),
    .rd_en   (in_accept),
    .rd_addr (set_idx),
    .rd_data (row_rd_bits)
  );

  assign row_rd = row_rd_bits;

  salc_way_sel #(
    .MAX_WAYS (MAX_WAYS)
  ) u_way_sel (
    .row    (row_rd),
    .row_ok (row_ok_r),
    .tag    (tag_r),
    .ways   (ways_eff),
    .res    (sel)
  );

  // counters and updated row
  always_comb begin
    access_nxt = sat_inc(access_count_r);
    hit_nxt    = sel.hit ? sat_inc(hit_count_r) : hit_count_r;
    miss_nxt   = sel.hit ? miss_count_r : sat_inc(miss_count_r);
    row_wr     = row_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_wr[w].valid = row_ok_r & row_rd[w].valid;
    end
    row_wr[sel.pick[IDX_W-1:0]] = '{valid: 1'b1, tag: tag_r, stamp: access_nxt};
  end

  // sets written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_seen_r <= '0;
    end else if (lookup_done) begin
      row_seen_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      access_count_r <= '0;
      hit_count_r    <= '0;
      miss_count_r   <= '0;
    end else if (lookup_done) begin
      access_count_r <= access_nxt;
      hit_count_r    <= hit_nxt;
      miss_count_r   <= miss_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (lookup_done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_done) begin
      out_tdata_r <= {3'b000, miss_nxt, hit_nxt, sel.evicted,
                      WAY_OUT_W'(sel.pick), sel.hit};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // an accepted item is looked up in the next cycle
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_LOOKUP))
    else $error("accepted item not followed by lookup");

  // a finished lookup leaves a result waiting
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_done |=> out_tvalid_r)
    else $error("lookup finished without a result");

  // a hit never replaces a line
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[0] && out_tdata_r[4]))
    else $error("result is both hit and eviction");

  // totals move only when a lookup finishes
  a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !lookup_done |=> ($stable(hit_count_r) && $stable(miss_count_r)))
    else $error("hit or miss total changed outside a lookup");

endmodule
